[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define BSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define BSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/bsc_pkg.sv]
// ---------------------------------------------------------------------------
// bsc_pkg
// Types and constants of the barometric compensation pipeline.
// ---------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned DataW     = 24;
  localparam int unsigned NW        = 61;   // linearized temperature, over 2^32
  localparam int unsigned HinW      = 153;  // Horner operand into a step
  localparam int unsigned HW        = 213;  // Horner step result
  localparam int unsigned ChunkW    = 31;
  localparam int unsigned NumChunks = 5;
  localparam int unsigned PartW     = 95;
  localparam int unsigned KsW       = 33;
  localparam int unsigned K1W       = 61;
  localparam int unsigned K0W       = 88;
  localparam int unsigned RoundPos  = 175;
  localparam int unsigned NumStages = 17;

  typedef logic signed [NW-1:0]     n_t;
  typedef logic signed [HinW-1:0]   h_in_t;
  typedef logic signed [HW-1:0]     acc_t;
  typedef logic signed [63:0]       prod_t;
  typedef logic signed [PartW-1:0]  part_t;
  typedef logic signed [ChunkW:0]   chunk_t;
  typedef logic signed [KsW-1:0]    ks_t;
  typedef logic signed [K1W-1:0]    k1_t;
  typedef logic signed [K0W-1:0]    k0_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RAW_ZERO = 2'd1,
    ST_CAL_ZERO = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_CALIB_TEMP   = 2'd0,
    REG_PRESS_FIRST  = 2'd1,
    REG_PRESS_SECOND = 2'd2,
    REG_PRESS_THIRD  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    status_e                   st;
    logic signed [DataW-1:0]   temp;
    k1_t                       k1;
    k0_t                       k0;
  } side_t;

endpackage

[sv/bsc_hstep.sv]
// ---------------------------------------------------------------------------
// bsc_hstep
// One Horner step h*n + add over four register stages: partial products,
// chunk merge, two half sums, final sum.
// ---------------------------------------------------------------------------
module bsc_hstep (
  input  logic           clk_i,
  input  logic [3:0]     en_i,
  input  bsc_pkg::h_in_t h_i,
  input  bsc_pkg::n_t    n_i,
  input  bsc_pkg::acc_t  add_i,
  output bsc_pkg::acc_t  h_o,
  output bsc_pkg::n_t    n_o
);

  bsc_pkg::prod_t pl_d [bsc_pkg::NumChunks];
  bsc_pkg::prod_t ph_d [bsc_pkg::NumChunks];
  bsc_pkg::prod_t pl_q [bsc_pkg::NumChunks];
  bsc_pkg::prod_t ph_q [bsc_pkg::NumChunks];
  bsc_pkg::part_t r_d  [bsc_pkg::NumChunks];
  bsc_pkg::part_t r_q  [bsc_pkg::NumChunks];
  bsc_pkg::n_t    n1_q, n2_q, n3_q, n4_q;
  bsc_pkg::acc_t  add1_q, add2_q;
  bsc_pkg::acc_t  s0_d, s1_d, s0_q, s1_q, h_q;
  bsc_pkg::chunk_t n_lo;
  logic signed [bsc_pkg::NW-bsc_pkg::ChunkW-1:0] n_hi;

  assign n_lo = $signed({1'b0, n_i[bsc_pkg::ChunkW-1:0]});
  assign n_hi = n_i[bsc_pkg::NW-1:bsc_pkg::ChunkW];

  for (genvar j = 0; j < bsc_pkg::NumChunks; j++) begin : g_chunk
    bsc_pkg::chunk_t hc;
    if (j < bsc_pkg::NumChunks - 1) begin : g_low
      assign hc = $signed({1'b0, h_i[j*bsc_pkg::ChunkW +: bsc_pkg::ChunkW]});
    end else begin : g_top
      assign hc = bsc_pkg::chunk_t'($signed(h_i[bsc_pkg::HinW-1:j*bsc_pkg::ChunkW]));
    end
    assign pl_d[j] = 64'(hc) * 64'(n_lo);
    assign ph_d[j] = 64'(hc) * 64'(n_hi);
    assign r_d[j]  = (bsc_pkg::part_t'(ph_q[j]) <<< bsc_pkg::ChunkW) +
                     bsc_pkg::part_t'(pl_q[j]);
  end

  assign s0_d = bsc_pkg::acc_t'(r_q[0]) +
                (bsc_pkg::acc_t'(r_q[1]) <<< bsc_pkg::ChunkW) +
                (bsc_pkg::acc_t'(r_q[2]) <<< (2 * bsc_pkg::ChunkW));
  assign s1_d = (bsc_pkg::acc_t'(r_q[3]) <<< (3 * bsc_pkg::ChunkW)) +
                (bsc_pkg::acc_t'(r_q[4]) <<< (4 * bsc_pkg::ChunkW)) + add2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int j = 0; j < bsc_pkg::NumChunks; j++) begin
        pl_q[j] <= pl_d[j];
        ph_q[j] <= ph_d[j];
      end
      n1_q   <= n_i;
      add1_q <= add_i;
    end
    if (en_i[1]) begin
      for (int j = 0; j < bsc_pkg::NumChunks; j++) begin
        r_q[j] <= r_d[j];
      end
      n2_q   <= n1_q;
      add2_q <= add1_q;
    end
    if (en_i[2]) begin
      s0_q <= s0_d;
      s1_q <= s1_d;
      n3_q <= n2_q;
    end
    if (en_i[3]) begin
      h_q  <= s0_q + s1_q;
      n4_q <= n3_q;
    end
  end

  assign h_o = h_q;
  assign n_o = n4_q;

endmodule

[sv/baro_sensor_compensation_top.sv]
// ---------------------------------------------------------------------------
// baro_sensor_compensation_top: barometric temperature/pressure compensation
// Pipeline: 4 setup stages, three 4-stage Horner steps in the linearized
// temperature, 1 rounding stage, from input transaction to result.
// Throughput: one transaction per cycle while the output is ready; bubbles collapse under back-pressure.
// Reset: calibration registers clear to zero, all pipeline valid bits clear.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module baro_sensor_compensation_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in, tdata: raw_pressure[23:0], raw_temperature[47:24]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  // stream out, tdata: temperature_out[23:0], pressure_out[47:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned NS = bsc_pkg::NumStages;

  // calibration registers
  logic [39:0] ctw_q;
  logic [47:0] cpf_q, cps_q;
  logic [31:0] cpt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctw_q <= '0;
      cpf_q <= '0;
      cps_q <= '0;
      cpt_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (bsc_pkg::reg_idx_e'(paddr[4:3]))
        bsc_pkg::REG_CALIB_TEMP:   ctw_q <= pwdata[39:0];
        bsc_pkg::REG_PRESS_FIRST:  cpf_q <= pwdata[47:0];
        bsc_pkg::REG_PRESS_SECOND: cps_q <= pwdata[47:0];
        bsc_pkg::REG_PRESS_THIRD:  cpt_q <= pwdata[31:0];
        default:                   ctw_q <= ctw_q;
      endcase
    end
  end

  always_comb begin
    unique case (bsc_pkg::reg_idx_e'(paddr[4:3]))
      bsc_pkg::REG_CALIB_TEMP:   prdata = {24'd0, ctw_q};
      bsc_pkg::REG_PRESS_FIRST:  prdata = {16'd0, cpf_q};
      bsc_pkg::REG_PRESS_SECOND: prdata = {16'd0, cps_q};
      bsc_pkg::REG_PRESS_THIRD:  prdata = {32'd0, cpt_q};
      default:                   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // coefficient fields
  logic [15:0]        t1, t2, c1, p5;
  logic signed [7:0]  t3, c2, c3, c6, c7, c9, c10;
  logic signed [16:0] c4, c5;
  logic signed [15:0] c8;

  assign t1  = ctw_q[15:0];
  assign t2  = ctw_q[31:16];
  assign t3  = ctw_q[39:32];
  assign c4  = $signed({cpf_q[15], cpf_q[15:0]}) - 17'sd16384;
  assign c5  = $signed({cpf_q[31], cpf_q[31:16]}) - 17'sd16384;
  assign c6  = cpf_q[39:32];
  assign c7  = cpf_q[47:40];
  assign p5  = cps_q[15:0];
  assign c1  = cps_q[31:16];
  assign c2  = cps_q[39:32];
  assign c3  = cps_q[47:40];
  assign c8  = cpt_q[15:0];
  assign c9  = cpt_q[23:16];
  assign c10 = cpt_q[31:24];

  // pipeline handshake
  logic [NS:1] v_q, en;

  always_comb begin
    en[NS] = ~v_q[NS] | m_axis_tready;
    for (int i = NS - 1; i >= 1; i--) begin
      en[i] = ~v_q[i] | en[i+1];
    end
  end

  assign s_axis_tready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= s_axis_tvalid;
      end
      for (int i = 2; i <= NS; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // stage 1
  bsc_pkg::status_e   st1_d, st1_q;
  logic signed [24:0] d1_q;
  logic [23:0]        u1_q;

  always_comb begin
    if (ctw_q == '0 && cpf_q == '0 && cps_q == '0 && cpt_q == '0) begin
      st1_d = bsc_pkg::ST_CAL_ZERO;
    end else if (s_axis_tdata == '0) begin
      st1_d = bsc_pkg::ST_RAW_ZERO;
    end else begin
      st1_d = bsc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      d1_q  <= $signed({1'b0, s_axis_tdata[47:24]}) - $signed({1'b0, t1, 8'd0});
      u1_q  <= s_axis_tdata[23:0];
      st1_q <= st1_d;
    end
  end

  // stage 2
  logic signed [24:0] u1s;
  logic signed [41:0] pa2_q, m5_2_q, m4_2_q;
  logic signed [49:0] dd2_d;
  logic [47:0]        dd2_q, uu2_q;
  logic signed [32:0] m7_2_q, m6_2_q;
  logic [23:0]        u2_q;
  bsc_pkg::status_e   st2_q;

  assign u1s   = $signed({1'b0, u1_q});
  assign dd2_d = 50'(d1_q) * 50'(d1_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      pa2_q  <= 42'(d1_q) * 42'($signed({1'b0, t2}));
      dd2_q  <= dd2_d[47:0];
      m7_2_q <= 33'(c7) * 33'(u1s);
      m6_2_q <= 33'(c6) * 33'(u1s);
      m5_2_q <= 42'(c5) * 42'(u1s);
      m4_2_q <= 42'(c4) * 42'(u1s);
      uu2_q  <= 48'(u1_q) * 48'(u1_q);
      u2_q   <= u1_q;
      st2_q  <= st1_q;
    end
  end

  // stage 3
  logic signed [56:0] q3_q, m9_3_q;
  logic signed [64:0] m8_3_q;
  logic [71:0]        uuu3_q;
  bsc_pkg::ks_t       k3_3_q, k2_3_q;
  logic signed [41:0] pa3_q, m5_3_q, m4_3_q;
  bsc_pkg::status_e   st3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      q3_q   <= 57'($signed({1'b0, dd2_q})) * 57'(t3);
      k3_3_q <= bsc_pkg::ks_t'(m7_2_q) + (bsc_pkg::ks_t'(c3) <<< 22);
      k2_3_q <= (bsc_pkg::ks_t'(c2) <<< 24) + bsc_pkg::ks_t'(m6_2_q);
      m9_3_q <= 57'(c9) * 57'($signed({1'b0, uu2_q}));
      m8_3_q <= 65'(c8) * 65'($signed({1'b0, uu2_q}));
      uuu3_q <= 72'(uu2_q) * 72'(u2_q);
      pa3_q  <= pa2_q;
      m5_3_q <= m5_2_q;
      m4_3_q <= m4_2_q;
      st3_q  <= st2_q;
    end
  end

  // stage 4
  bsc_pkg::n_t        n4_q;
  bsc_pkg::k1_t       k1_4_q;
  logic signed [80:0] m10_4_q;
  bsc_pkg::k0_t       t04_4_q;
  logic signed [64:0] m8_4_q;
  bsc_pkg::ks_t       k3_4_q, k2_4_q;
  bsc_pkg::status_e   st4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      n4_q    <= (bsc_pkg::n_t'(pa3_q) <<< 18) + bsc_pkg::n_t'(q3_q);
      k1_4_q  <= (bsc_pkg::k1_t'($signed({1'b0, c1})) <<< 42) +
                 (bsc_pkg::k1_t'(m5_3_q) <<< 19) + bsc_pkg::k1_t'(m9_3_q);
      m10_4_q <= 81'(c10) * 81'($signed({1'b0, uuu3_q}));
      t04_4_q <= (bsc_pkg::k0_t'($signed({1'b0, p5})) <<< 68) +
                 (bsc_pkg::k0_t'(m4_3_q) <<< 45);
      m8_4_q  <= m8_3_q;
      k3_4_q  <= k3_3_q;
      k2_4_q  <= k2_3_q;
      st4_q   <= st3_q;
    end
  end

  // stage 5 side data: rounded temperature, constant terms for later steps
  logic signed [29:0]            tq5;
  logic signed [bsc_pkg::DataW-1:0] tsat5;
  bsc_pkg::side_t                side_d5;
  bsc_pkg::side_t                side_q [5:NS-1];

  assign tq5 = 30'($signed(n4_q[60:32])) + 30'($signed({1'b0, n4_q[31]}));

  always_comb begin
    if (tq5 > 30'sd8388607) begin
      tsat5 = 24'sh7FFFFF;
    end else if (tq5 < -30'sd8388608) begin
      tsat5 = 24'sh800000;
    end else begin
      tsat5 = tq5[23:0];
    end
    side_d5.st   = st4_q;
    side_d5.temp = tsat5;
    side_d5.k1   = k1_4_q;
    side_d5.k0   = t04_4_q + (bsc_pkg::k0_t'(m8_4_q) <<< 17) + bsc_pkg::k0_t'(m10_4_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      side_q[5] <= side_d5;
    end
    for (int i = 6; i <= NS - 1; i++) begin
      if (en[i]) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Horner steps, sum held over 2^181
  bsc_pkg::acc_t ha, hb, hc;
  bsc_pkg::n_t   na, nb, nc;

  bsc_hstep u_step_a (
    .clk_i (clk_i),
    .en_i  (en[8:5]),
    .h_i   (bsc_pkg::h_in_t'(k3_4_q)),
    .n_i   (n4_q),
    .add_i (bsc_pkg::acc_t'(k2_4_q) <<< 53),
    .h_o   (ha),
    .n_o   (na)
  );

  bsc_hstep u_step_b (
    .clk_i (clk_i),
    .en_i  (en[12:9]),
    .h_i   ($signed(ha[bsc_pkg::HinW-1:0])),
    .n_i   (na),
    .add_i (bsc_pkg::acc_t'(side_q[8].k1) <<< 85),
    .h_o   (hb),
    .n_o   (nb)
  );

  bsc_hstep u_step_c (
    .clk_i (clk_i),
    .en_i  (en[16:13]),
    .h_i   ($signed(hb[bsc_pkg::HinW-1:0])),
    .n_i   (nb),
    .add_i (bsc_pkg::acc_t'(side_q[12].k0) <<< 116),
    .h_o   (hc),
    .n_o   (nc)
  );

  // output stage: round to 1/64 Pa, saturate
  bsc_pkg::acc_t    rsum;
  logic [23:0]      press_d;
  logic [23:0]      out_temp_q, out_press_q;
  bsc_pkg::status_e out_st_q;
  logic             n_sign;

  assign rsum   = hc + (bsc_pkg::acc_t'(1) <<< (bsc_pkg::RoundPos - 1));
  assign n_sign = nc[bsc_pkg::NW-1];

  always_comb begin
    if (rsum[bsc_pkg::HW-1]) begin
      press_d = '0;
    end else if (|rsum[bsc_pkg::HW-2:bsc_pkg::RoundPos+24]) begin
      press_d = '1;
    end else begin
      press_d = rsum[bsc_pkg::RoundPos+23:bsc_pkg::RoundPos];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS]) begin
      out_st_q <= side_q[NS-1].st;
      if (side_q[NS-1].st == bsc_pkg::ST_OK) begin
        out_temp_q  <= side_q[NS-1].temp;
        out_press_q <= press_d;
      end else begin
        out_temp_q  <= '0;
        out_press_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = v_q[NS];
  assign m_axis_tdata  = {out_press_q, out_temp_q};
  assign m_axis_tuser  = out_st_q;

  // sign of the carried temperature term is unused past the last step
  logic unused_n;
  assign unused_n = n_sign;

  `BSC_ASSERT(a_ready_when_out_free, !v_q[NS] |-> s_axis_tready, "input stalled with free output")
  `BSC_ASSERT(a_status_zero_payload, m_axis_tvalid && (m_axis_tuser != bsc_pkg::ST_OK) |-> m_axis_tdata == '0, "nonzero payload with error status")
  `BSC_ASSERT(a_accept_fills_stage1, s_axis_tvalid && s_axis_tready |=> v_q[1], "accepted transaction lost at entry")
  `BSC_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

endmodule

[bench/tb.sv]
// ---------------------------------------------------------------------------
// tb: barometric compensation testbench
// Streams raw pressure/temperature pairs through the block under several
// calibration settings. Each result is checked against an exact wide-integer
// model of the compensation polynomial. Both stream sides idle at random, but for one gap-free phase.
// ---------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [23:0] raw_press;
    logic [23:0] raw_temp;
  } sample_t;

  typedef struct {
    logic [23:0]      temp;
    logic [23:0]      press;
    bsc_pkg::status_e st;
  } comp_t;

  localparam int unsigned FracE = 181;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  baro_sensor_compensation_top i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sample_t     sample_q[$];
  comp_t       comp_q[$];
  logic [39:0] cal_temp = '0;
  logic [47:0] cal_p1 = '0;
  logic [47:0] cal_p2 = '0;
  logic [31:0] cal_p3 = '0;
  int          errors = 0;
  int          send_gap = 0;
  int          hold_cnt = 0;
  int          recv_gap = 0;
  int          idle_cycles = 0;
  bit          no_gaps = 0;
  bit          hold_req = 0;
  bit          in_fire = 0;

  function automatic comp_t compensate(logic [23:0] up, logic [23:0] ut);
    comp_t             r;
    logic signed [127:0] d, nt, tq, rnd;
    logic signed [511:0] coef[11], upw[4], tpw[4], acc, term, half;
    int unsigned         ua[11], tb_[11], den[11];
    ua  = '{0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 3};
    tb_ = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 0};
    den = '{0, 54, 104, 159, 20, 77, 128, 181, 48, 96, 65};
    r.temp = '0;
    r.press = '0;
    if (cal_temp == '0 && cal_p1 == '0 && cal_p2 == '0 && cal_p3 == '0) begin
      r.st = bsc_pkg::ST_CAL_ZERO;
      return r;
    end
    if (up == '0 && ut == '0) begin
      r.st = bsc_pkg::ST_RAW_ZERO;
      return r;
    end
    r.st = bsc_pkg::ST_OK;
    d  = $signed({104'b0, ut}) - $signed({104'b0, cal_temp[15:0], 8'b0});
    nt = d * $signed({112'b0, cal_temp[31:16]}) * 128'sd262144
       + d * d * $signed(cal_temp[39:32]);
    rnd = 128'sd1;
    rnd = rnd <<< 31;
    tq = (nt + rnd) >>> 32;
    if (tq > 128'sd8388607) r.temp = 24'h7FFFFF;
    else if (tq < -128'sd8388608) r.temp = 24'h800000;
    else r.temp = tq[23:0];
    coef[0]  = $signed({493'b0, cal_p2[15:0], 3'b0});
    coef[1]  = $signed({496'b0, cal_p2[31:16]});
    coef[2]  = $signed(cal_p2[39:32]);
    coef[3]  = $signed(cal_p2[47:40]);
    coef[4]  = $signed(cal_p1[15:0]);
    coef[4]  = coef[4] - 512'sd16384;
    coef[5]  = $signed(cal_p1[31:16]);
    coef[5]  = coef[5] - 512'sd16384;
    coef[6]  = $signed(cal_p1[39:32]);
    coef[7]  = $signed(cal_p1[47:40]);
    coef[8]  = $signed(cal_p3[15:0]);
    coef[9]  = $signed(cal_p3[23:16]);
    coef[10] = $signed(cal_p3[31:24]);
    upw[0] = 512'sd1;
    tpw[0] = 512'sd1;
    upw[1] = $signed({488'b0, up});
    tpw[1] = nt;
    for (int k = 2; k < 4; k++) begin
      upw[k] = upw[k-1] * upw[1];
      tpw[k] = tpw[k-1] * tpw[1];
    end
    acc = '0;
    for (int k = 0; k < 11; k++) begin
      term = coef[k] * upw[ua[k]] * tpw[tb_[k]];
      acc = acc + (term <<< (FracE - den[k]));
    end
    half = 512'sd1;
    half = half <<< (FracE - 7);
    acc = (acc + half) >>> (FracE - 6);
    if (acc < 0) r.press = '0;
    else if (acc > 512'sd16777215) r.press = 24'hFFFFFF;
    else r.press = acc[23:0];
    return r;
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_fire) begin
      in_fire = 0;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        sample_t s;
        s = sample_q.pop_front();
        s_axis_tdata <= {s.raw_temp, s.raw_press};
        s_axis_tvalid <= 1'b1;
        if (!no_gaps) begin
          int c;
          c = $urandom_range(0, 99);
          send_gap = (c < 70) ? 0 : (c < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (no_gaps) begin
      m_axis_tready <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      int c;
      c = $urandom_range(0, 99);
      recv_gap = (c < 70) ? 0 : (c < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      m_axis_tready <= 1'b1;
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    bit moved;
    moved = 0;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      comp_q.push_back(compensate(s_axis_tdata[23:0], s_axis_tdata[47:24]));
      in_fire = 1;
      moved = 1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      moved = 1;
      if (comp_q.size() == 0) begin
        $error("result transaction with no expectation");
        errors++;
      end else begin
        comp_t x;
        x = comp_q.pop_front();
        if (m_axis_tdata[23:0] !== x.temp) begin
          $error("temperature_out: expected %0d actual %0d",
                 $signed(x.temp), $signed(m_axis_tdata[23:0]));
          errors++;
        end
        if (m_axis_tdata[47:24] !== x.press) begin
          $error("pressure_out: expected %0d actual %0d", x.press, m_axis_tdata[47:24]);
          errors++;
        end
        if (m_axis_tuser !== x.st) begin
          $error("status: expected %0d actual %0d", x.st, m_axis_tuser);
          errors++;
        end
      end
    end
    if (moved || (comp_q.size() == 0 && sample_q.size() == 0 && !s_axis_tvalid))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= 5000) begin
      $display("FAIL baro_sensor_compensation_top");
      $finish;
    end
  end

  task automatic reg_write(bsc_pkg::reg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bsc_pkg::REG_CALIB_TEMP:   cal_temp = val[39:0];
      bsc_pkg::REG_PRESS_FIRST:  cal_p1 = val[47:0];
      bsc_pkg::REG_PRESS_SECOND: cal_p2 = val[47:0];
      default:                   cal_p3 = val[31:0];
    endcase
  endtask

  task automatic set_calib(logic [39:0] t, logic [47:0] a, logic [47:0] b, logic [31:0] c);
    reg_write(bsc_pkg::REG_CALIB_TEMP, {24'b0, t});
    reg_write(bsc_pkg::REG_PRESS_FIRST, {16'b0, a});
    reg_write(bsc_pkg::REG_PRESS_SECOND, {16'b0, b});
    reg_write(bsc_pkg::REG_PRESS_THIRD, {32'b0, c});
  endtask

  task automatic push(logic [23:0] p, logic [23:0] t);
    sample_t s;
    s.raw_press = p;
    s.raw_temp = t;
    sample_q.push_back(s);
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || s_axis_tvalid || comp_q.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        push(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)));
      else
        push(24'($urandom_range(24'h500000, 24'h700000)),
             24'($urandom_range(24'h700000, 24'h8C0000)));
    end
  endtask

  initial begin
    #1 rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // calibration still clear, raw zero too
    push(24'h0, 24'h0);
    push(24'hFFFFFF, 24'hFFFFFF);
    push(24'h6B1234, 24'h7F0000);
    drain();

    set_calib({8'hF6, 16'h4D80, 16'h6B6A}, {8'h0F, 8'h04, 16'hFFDA, 16'hFC8F},
              {8'hD5, 8'h04, 16'h7A6E, 16'h4F25}, {8'h00, 8'h0F, 16'h1246});
    push(24'h0, 24'h0);
    push(24'h0, 24'hFFFFFF);
    push(24'hFFFFFF, 24'h0);
    push(24'hFFFFFF, 24'hFFFFFF);
    push(24'h000001, 24'h000001);
    push(24'h800000, 24'h800000);
    push(24'h6B8000, 24'h7F5000);
    push(24'h5A0000, 24'h860000);
    push(24'h7FFFFF, 24'h6B6A00);
    drain();
    hold_req = 1;
    push_random(400);
    drain();

    set_calib('1, '1, '1, '1);
    push(24'h0, 24'h0);
    push(24'hFFFFFF, 24'hFFFFFF);
    push(24'h0, 24'h000001);
    push_random(250);
    drain();

    set_calib({8'h80, 16'hFFFF, 16'h0000}, {8'h80, 8'h7F, 16'h8000, 16'h7FFF},
              {8'h7F, 8'h80, 16'hFFFF, 16'h0000}, {8'h7F, 8'h80, 16'h7FFF});
    no_gaps = 1;
    push_random(250);
    drain();
    no_gaps = 0;

    for (int ph = 0; ph < 3; ph++) begin
      set_calib(40'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                48'({$urandom, $urandom}), $urandom);
      push_random(250);
      drain();
    end

    set_calib('0, '0, '0, '0);
    push(24'h0, 24'h0);
    push_random(30);
    drain();

    if (errors == 0)
      $display("PASS baro_sensor_compensation_top");
    else
      $display("FAIL baro_sensor_compensation_top");
    $finish;
  end

endmodule
